FILE: rtl/furic_pkg.sv
`default_nettype none

package furic_pkg;

    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_NUL     = 8'h00;

    // "file://" is seven characters, "localhost" nine
    localparam logic [3:0] SCHEME_LEN = 4'd7;
    localparam logic [3:0] HOST_LEN   = 4'd9;

    // what the back end has to do with one queued word
    typedef enum logic [1:0] {
        CMD_PREFIX = 2'd0,
        CMD_PLAIN  = 2'd1,
        CMD_ESCAPE = 2'd2,
        CMD_FAIL   = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] value;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [7:0] scheme_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h66;  // f
            4'd1:    c = 8'h69;  // i
            4'd2:    c = 8'h6C;  // l
            4'd3:    c = 8'h65;  // e
            4'd4:    c = 8'h3A;  // :
            4'd5:    c = 8'h2F;  // /
            4'd6:    c = 8'h2F;  // /
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] host_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h6C;  // l
            4'd1:    c = 8'h6F;  // o
            4'd2:    c = 8'h63;  // c
            4'd3:    c = 8'h61;  // a
            4'd4:    c = 8'h6C;  // l
            4'd5:    c = 8'h68;  // h
            4'd6:    c = 8'h6F;  // o
            4'd7:    c = 8'h73;  // s
            4'd8:    c = 8'h74;  // t
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // bit 4 set: not a hex digit
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        logic [4:0] n;
        if (c >= 8'h30 && c <= 8'h39) begin
            n = {1'b0, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            n = {1'b0, c[3:0] + 4'd9};
        end else begin
            n = 5'h10;
        end
        return n;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'b0, nib};
        end else begin
            c = 8'h37 + {4'b0, nib};
        end
        return c;
    endfunction

    function automatic logic keeps_plain(input logic [7:0] v);
        return (v >= 8'h61 && v <= 8'h7A) || (v >= 8'h41 && v <= 8'h5A) ||
               (v >= 8'h30 && v <= 8'h39) || v == 8'h2F || v == 8'h2D ||
               v == 8'h5F || v == 8'h2E || v == 8'h7E || v == 8'h3A;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/furic_front.sv
`default_nettype none

module furic_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [7:0]           s_in_byte,
    input  wire logic                 s_in_last,
    input  wire furic_pkg::q_status_t q_status,
    output logic                      push,
    output furic_pkg::cmd_t           push_cmd
);

    typedef enum logic [4:0] {
        PH_PREFIX = 5'b00001,
        PH_AUTH   = 5'b00010,
        PH_PATH   = 5'b00100,
        PH_ESC1   = 5'b01000,
        PH_ESC2   = 5'b10000
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [3:0] idx_reg, idx_next;
    logic [3:0] hi_reg, hi_next;
    logic       err_reg, err_next;

    logic       take;
    logic       has_cmd;
    logic [4:0] nib;
    logic [7:0] decoded;
    furic_pkg::cmd_t cmd;

    assign s_ready = !q_status.full;
    assign take    = s_valid && s_ready;
    assign nib     = furic_pkg::nibble_of(s_in_byte);
    assign decoded = {hi_reg, nib[3:0]};

    always_comb begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        hi_next    = hi_reg;
        err_next   = err_reg;
        has_cmd    = 1'b0;
        cmd.kind   = furic_pkg::CMD_PLAIN;
        cmd.value  = s_in_byte;
        cmd.last   = s_in_last;

        if (!err_reg) begin
            unique case (phase_reg)
                PH_PREFIX: begin
                    if (idx_reg < furic_pkg::SCHEME_LEN &&
                        s_in_byte == furic_pkg::scheme_char(idx_reg)) begin
                        if (idx_reg == furic_pkg::SCHEME_LEN - 4'd1) begin
                            phase_next = PH_AUTH;
                            idx_next   = 4'd0;
                        end else begin
                            idx_next = idx_reg + 4'd1;
                        end
                    end else begin
                        err_next = 1'b1;
                    end
                end
                PH_AUTH: begin
                    if (s_in_byte == furic_pkg::CH_SLASH) begin
                        if (idx_reg == 4'd0 || idx_reg == furic_pkg::HOST_LEN) begin
                            phase_next = PH_PATH;
                            has_cmd    = 1'b1;
                            cmd.kind   = furic_pkg::CMD_PREFIX;
                        end else begin
                            err_next = 1'b1;
                        end
                    end else if (idx_reg < furic_pkg::HOST_LEN &&
                                 s_in_byte == furic_pkg::host_char(idx_reg)) begin
                        idx_next = idx_reg + 4'd1;
                    end else begin
                        err_next = 1'b1;
                    end
                end
                PH_PATH: begin
                    if (s_in_byte == furic_pkg::CH_PERCENT) begin
                        phase_next = PH_ESC1;
                    end else if (s_in_byte == furic_pkg::CH_NUL) begin
                        err_next = 1'b1;
                    end else begin
                        has_cmd  = 1'b1;
                        cmd.kind = furic_pkg::keeps_plain(s_in_byte) ?
                                   furic_pkg::CMD_PLAIN : furic_pkg::CMD_ESCAPE;
                    end
                end
                PH_ESC1: begin
                    if (nib[4]) begin
                        err_next = 1'b1;
                    end else begin
                        hi_next    = nib[3:0];
                        phase_next = PH_ESC2;
                    end
                end
                PH_ESC2: begin
                    if (nib[4] || decoded == furic_pkg::CH_NUL) begin
                        err_next = 1'b1;
                    end else begin
                        has_cmd    = 1'b1;
                        cmd.value  = decoded;
                        cmd.kind   = furic_pkg::keeps_plain(decoded) ?
                                     furic_pkg::CMD_PLAIN : furic_pkg::CMD_ESCAPE;
                        phase_next = PH_PATH;
                    end
                end
                default: begin
                    err_next = 1'b1;
                end
            endcase
        end

        if (err_next) begin
            has_cmd = 1'b0;
        end

        if (s_in_last) begin
            if (err_next || phase_next != PH_PATH || !has_cmd) begin
                cmd.kind  = furic_pkg::CMD_FAIL;
                cmd.value = furic_pkg::CH_NUL;
            end
            has_cmd    = 1'b1;
            phase_next = PH_PREFIX;
            idx_next   = 4'd0;
            hi_next    = 4'd0;
            err_next   = 1'b0;
        end
    end

    assign push     = take && has_cmd;
    assign push_cmd = cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_PREFIX;
            idx_reg   <= 4'd0;
            hi_reg    <= 4'd0;
            err_reg   <= 1'b0;
        end else if (take) begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            hi_reg    <= hi_next;
            err_reg   <= err_next;
        end
    end

    a_last_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && s_in_last) |=> (phase_reg == PH_PREFIX && !err_reg && idx_reg == 4'd0))
        else $error("uri state not cleared after final word");

    a_last_always_pushes: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && s_in_last) |-> (push && push_cmd.last))
        else $error("final word gave no closing command");

endmodule

`default_nettype wire

FILE: rtl/furic_queue.sv
`default_nettype none

module furic_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire furic_pkg::cmd_t      push_cmd,
    input  wire logic                 pop,
    output furic_pkg::cmd_t           head_cmd,
    output furic_pkg::q_status_t      q_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    furic_pkg::cmd_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head_cmd       = slot_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == FULL_CNT);
    assign q_status.empty = (count_reg == '0);

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!q_status.full || pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_status.empty)
        else $error("queue read while empty");

endmodule

`default_nettype wire

FILE: rtl/furic_back.sv
`default_nettype none

module furic_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire furic_pkg::cmd_t      head_cmd,
    input  wire furic_pkg::q_status_t q_status,
    output logic                      pop,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [7:0]                m_out_byte,
    output logic                      m_out_last,
    output logic                      m_failed
);

    logic [2:0] pos_reg;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       failed_reg;

    logic       load;
    logic       final_pos;
    logic [7:0] byte_next;

    // output register takes a queued word whenever it is empty or being drained
    assign load = !q_status.empty && (!valid_reg || m_ready);

    always_comb begin
        final_pos = 1'b1;
        byte_next = head_cmd.value;
        unique case (head_cmd.kind)
            furic_pkg::CMD_PREFIX: begin
                final_pos = (pos_reg == 3'd7);
                byte_next = (pos_reg == 3'd7) ? furic_pkg::CH_SLASH :
                            furic_pkg::scheme_char({1'b0, pos_reg});
            end
            furic_pkg::CMD_PLAIN: begin
                byte_next = head_cmd.value;
            end
            furic_pkg::CMD_ESCAPE: begin
                final_pos = (pos_reg == 3'd2);
                if (pos_reg == 3'd0) begin
                    byte_next = furic_pkg::CH_PERCENT;
                end else if (pos_reg == 3'd1) begin
                    byte_next = furic_pkg::hex_char(head_cmd.value[7:4]);
                end else begin
                    byte_next = furic_pkg::hex_char(head_cmd.value[3:0]);
                end
            end
            furic_pkg::CMD_FAIL: begin
                byte_next = furic_pkg::CH_NUL;
            end
            default: begin
                byte_next = furic_pkg::CH_NUL;
            end
        endcase
    end

    assign pop = load && final_pos;

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg   <= byte_next;
            last_reg   <= head_cmd.last && final_pos;
            failed_reg <= (head_cmd.kind == furic_pkg::CMD_FAIL);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pos_reg   <= 3'd0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
            if (load) begin
                pos_reg <= final_pos ? 3'd0 : pos_reg + 3'd1;
            end
        end
    end

    assign m_valid    = valid_reg;
    assign m_out_byte = byte_reg;
    assign m_out_last = last_reg;
    assign m_failed   = failed_reg;

    a_fail_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_failed) |-> (m_out_last && m_out_byte == furic_pkg::CH_NUL))
        else $error("failure word not closing or not zero");

endmodule

`default_nettype wire

FILE: rtl/file_uri_canonicalizer_unit.sv
`default_nettype none

// file uri canonicaliser. takes a uri one byte word at a time (s_in_last on the final
// byte), checks the "file://" scheme and an empty or "localhost" authority, then
// percent-decodes the path and re-encodes it: letters, digits and / - _ . ~ : pass
// through, any other byte leaves as %XX with uppercase hex. the canonical "file://"
// comes out together with the first path slash. any error (bad prefix or authority,
// raw or decoded nul, bad hex digit, truncated escape, no path) gives a single word
// with m_failed high, m_out_last high and a zero byte on the final input byte; words
// already sent for that uri are to be discarded. rate: the front end accepts one byte
// a cycle while its command queue (QUEUE_DEPTH entries) has room, and the back end
// sends one output word a cycle while a command is queued and m_ready allows; a plain
// byte gives one word, an escaped byte three and the slash that opens the path eight,
// so the back end sets the sustained rate. an output register parts the result side
// from the queue, so input flows while a word waits on m_ready. no clearing pass after reset.

module file_uri_canonicalizer_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // input word channel
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_byte,
    input  wire logic       s_in_last,
    // result word channel
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_out_last,
    output logic            m_failed
);

    // front end to queue
    logic                 push;
    furic_pkg::cmd_t      push_cmd;
    // queue to back end
    logic                 pop;
    furic_pkg::cmd_t      head_cmd;
    furic_pkg::q_status_t q_status;

    // parses and classifies each input byte into at most one command
    furic_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .s_in_last (s_in_last),
        .q_status  (q_status),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    // short command queue so parsing and expansion stall independently
    furic_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_status (q_status)
    );

    // expands each command into one to eight output words
    furic_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_cmd   (head_cmd),
        .q_status   (q_status),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_last (m_out_last),
        .m_failed   (m_failed)
    );

endmodule

`default_nettype wire
